>>> rtl/mkp_pkg.sv
// ----------------------------------------------------------------------------
// Keypad scanner package
// Shared types, state codes, register indexes and the key map.
// ----------------------------------------------------------------------------
package mkp_pkg;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_SETTLE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCAN_GAP = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE = 2'd2;

   localparam logic [1:0] PH_SCAN     = 2'd0;
   localparam logic [1:0] PH_GAP      = 2'd1;
   localparam logic [1:0] PH_DEBOUNCE = 2'd2;

   localparam logic [1:0] PUR_PRESS   = 2'd0;
   localparam logic [1:0] PUR_VERIFY  = 2'd1;
   localparam logic [1:0] PUR_RELEASE = 2'd2;

   localparam int unsigned FIELD_ROWS = 4;
   localparam int unsigned FIELD_COLS = 4;

   localparam logic [15:0] TIMER_MAX = 16'hFFFF;

   typedef struct packed {
      logic [7:0]  settle_ticks;
      logic [15:0] scan_gap_ticks;
      logic [15:0] debounce_ticks;
   } cfg_type;

   typedef struct packed {
      logic [3:0] row_drive;
      logic       key_ready;
      logic [7:0] key_char;
      logic       bounce_seen;
   } rsp_type;

   localparam logic [7:0] KEYMAP [16] = '{
      "1", "2", "3", "A",
      "4", "5", "6", "B",
      "7", "8", "9", "C",
      "*", "0", "#", "D"
   };

   function automatic logic [7:0] key_ascii(input logic [1:0] row, input logic [1:0] col);
      return KEYMAP[{row, col}];
   endfunction

endpackage

>>> rtl/mkp_chan_if.sv
// ----------------------------------------------------------------------------
// Keypad scanner channels
// Valid/ready channels for the tick input and the scan result.
// ----------------------------------------------------------------------------
interface mkp_req_if;
   logic       valid;
   logic       ready;
   logic [3:0] column_levels;

   modport source (output valid, output column_levels, input ready);
   modport sink (input valid, input column_levels, output ready);
endinterface

interface mkp_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] row_drive;
   logic       key_ready;
   logic [7:0] key_char;
   logic       bounce_seen;

   modport source (output valid, output row_drive, output key_ready, output key_char,
                   output bounce_seen, input ready);
   modport sink (input valid, input row_drive, input key_ready, input key_char,
                 input bounce_seen, output ready);
endinterface

>>> rtl/mkp_core.sv
// ----------------------------------------------------------------------------
// Keypad scanner core
// Scan, debounce and release state machine, advanced once per tick.
// ----------------------------------------------------------------------------
module mkp_core #(
   parameter int unsigned ROW_COUNT = 4,
   parameter int unsigned COL_COUNT = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [3:0]       column_levels,
   input  mkp_pkg::cfg_type cfg,
   output mkp_pkg::rsp_type result
);

   localparam int unsigned ROW_W   = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
   localparam int unsigned COL_LIM = (COL_COUNT < mkp_pkg::FIELD_COLS) ?
                                     COL_COUNT : mkp_pkg::FIELD_COLS;
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROW_COUNT - 1);

   logic [1:0]       phase_ff, phase_in;
   logic [1:0]       purpose_ff, purpose_in;
   logic [ROW_W-1:0] scan_row_ff, scan_row_in;
   logic [15:0]      timer_ff, timer_in;
   logic [1:0]       held_row_ff, held_row_in;
   logic [1:0]       held_col_ff, held_col_in;

   logic [15:0]      timer_inc;
   logic [ROW_W-1:0] row_cur;
   logic             hit;
   logic [1:0]       hit_col;

   always_comb begin
      hit     = 1'b0;
      hit_col = 2'd0;
      for (int c = mkp_pkg::FIELD_COLS - 1; c >= 0; c--) begin
         if (c < COL_LIM && !column_levels[c]) begin
            hit     = 1'b1;
            hit_col = 2'(c);
         end
      end
   end

   always_comb begin
      timer_inc   = (timer_ff == mkp_pkg::TIMER_MAX) ? timer_ff : timer_ff + 16'd1;
      row_cur     = (32'(scan_row_ff) >= ROW_COUNT) ? '0 : scan_row_ff;
      phase_in    = phase_ff;
      purpose_in  = purpose_ff;
      scan_row_in = scan_row_ff;
      timer_in    = timer_inc;
      held_row_in = held_row_ff;
      held_col_in = held_col_ff;
      result      = '0;
      result.row_drive = 4'hF;
      case (phase_ff)
         mkp_pkg::PH_GAP: begin
            if (timer_inc >= cfg.scan_gap_ticks) begin
               phase_in    = mkp_pkg::PH_SCAN;
               scan_row_in = '0;
               timer_in    = '0;
            end
         end
         mkp_pkg::PH_DEBOUNCE: begin
            if (timer_inc >= cfg.debounce_ticks) begin
               if (purpose_ff == mkp_pkg::PUR_RELEASE) begin
                  result.key_ready = 1'b1;
                  result.key_char  = mkp_pkg::key_ascii(held_row_ff, held_col_ff);
                  purpose_in       = mkp_pkg::PUR_PRESS;
               end
               phase_in    = mkp_pkg::PH_SCAN;
               scan_row_in = '0;
               timer_in    = '0;
            end
         end
         default: begin
            phase_in    = mkp_pkg::PH_SCAN;
            scan_row_in = row_cur;
            for (int r = 0; r < mkp_pkg::FIELD_ROWS; r++) begin
               result.row_drive[r] = (32'(row_cur) != r);
            end
            if (timer_inc >= {8'd0, cfg.settle_ticks}) begin
               if (!hit && row_cur != ROW_LAST) begin
                  scan_row_in = row_cur + ROW_W'(1);
                  timer_in    = '0;
               end else begin
                  scan_row_in = '0;
                  timer_in    = '0;
                  case (purpose_ff)
                     mkp_pkg::PUR_VERIFY: begin
                        if (hit && 32'(row_cur) == 32'(held_row_ff) &&
                            hit_col == held_col_ff) begin
                           purpose_in = mkp_pkg::PUR_RELEASE;
                        end else begin
                           result.bounce_seen = 1'b1;
                           purpose_in         = mkp_pkg::PUR_PRESS;
                        end
                     end
                     mkp_pkg::PUR_RELEASE: begin
                        if (hit) begin
                           if (cfg.scan_gap_ticks != '0) begin
                              phase_in = mkp_pkg::PH_GAP;
                           end
                        end else if (cfg.debounce_ticks != '0) begin
                           phase_in = mkp_pkg::PH_DEBOUNCE;
                        end else begin
                           result.key_ready = 1'b1;
                           result.key_char  = mkp_pkg::key_ascii(held_row_ff, held_col_ff);
                           purpose_in       = mkp_pkg::PUR_PRESS;
                        end
                     end
                     default: begin
                        purpose_in = mkp_pkg::PUR_PRESS;
                        if (hit) begin
                           held_row_in = 2'(row_cur);
                           held_col_in = hit_col;
                           purpose_in  = mkp_pkg::PUR_VERIFY;
                           if (cfg.debounce_ticks != '0) begin
                              phase_in = mkp_pkg::PH_DEBOUNCE;
                           end
                        end else if (cfg.scan_gap_ticks != '0) begin
                           phase_in = mkp_pkg::PH_GAP;
                        end
                     end
                  endcase
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= mkp_pkg::PH_SCAN;
         purpose_ff  <= mkp_pkg::PUR_PRESS;
         scan_row_ff <= '0;
         timer_ff    <= '0;
         held_row_ff <= '0;
         held_col_ff <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         purpose_ff  <= purpose_in;
         scan_row_ff <= scan_row_in;
         timer_ff    <= timer_in;
         held_row_ff <= held_row_in;
         held_col_ff <= held_col_in;
      end
   end

endmodule

>>> rtl/matrix_keypad_scanner_debounced.sv
// ----------------------------------------------------------------------------
// Debounced matrix keypad scanner
// Scans the rows, debounces a press and reports the key code on release.
// ----------------------------------------------------------------------------
// Each transaction on req_if is one time tick carrying the sampled column
// levels, and each one yields exactly one transaction on rsp_if with the row
// drive for that tick, a key code on release of a debounced key, or a bounce
// flag when the verify scan fails. One tick is taken every clock cycle while
// rsp_if is not stalled; a tick's result goes from the input register into
// the result register, the state machine in the core being updated once per
// tick between the input register and the result register. The user must
// write the timing registers through the csr_ port only while no tick is in
// flight; the block itself does not enforce this.
module matrix_keypad_scanner_debounced #(
   parameter int unsigned ROW_COUNT = 4,
   parameter int unsigned COL_COUNT = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   mkp_req_if.sink                             req_if,
   mkp_rsp_if.source                           rsp_if,
   input  logic                                csr_wr_en,
   input  logic [mkp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mkp_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   mkp_pkg::cfg_type cfg_ff;
   logic             in_valid_ff;
   logic [3:0]       in_cols_ff;
   logic             out_valid_ff;
   mkp_pkg::rsp_type out_ff;
   mkp_pkg::rsp_type step_rsp;
   logic             step;
   logic             req_accept;

   assign step          = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready  = !in_valid_ff || step;
   assign req_accept    = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.settle_ticks   <= 8'd1;
         cfg_ff.scan_gap_ticks <= 16'd20;
         cfg_ff.debounce_ticks <= 16'd50;
      end else if (csr_wr_en) begin
         case (csr_index)
            mkp_pkg::CSR_SETTLE:   cfg_ff.settle_ticks   <= csr_wdata[7:0];
            mkp_pkg::CSR_SCAN_GAP: cfg_ff.scan_gap_ticks <= csr_wdata;
            mkp_pkg::CSR_DEBOUNCE: cfg_ff.debounce_ticks <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_cols_ff <= req_if.column_levels;
      end
   end

   mkp_core #(
      .ROW_COUNT (ROW_COUNT),
      .COL_COUNT (COL_COUNT)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .column_levels (in_cols_ff),
      .cfg           (cfg_ff),
      .result        (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_if.ready) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_ff <= step_rsp;
      end
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.row_drive   = out_ff.row_drive;
   assign rsp_if.key_ready   = out_ff.key_ready;
   assign rsp_if.key_char    = out_ff.key_char;
   assign rsp_if.bounce_seen = out_ff.bounce_seen;

   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> !(rsp_if.key_ready && rsp_if.bounce_seen))
      else $error("Key and bounce reported in one transaction.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.key_ready) |-> (rsp_if.key_char == 8'd0))
      else $error("Key code present without a key.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> ($countones(~rsp_if.row_drive) <= 1))
      else $error("More than one row driven.");

   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !step) |=> (in_valid_ff && $stable(in_cols_ff)))
      else $error("Stalled input register lost its transaction.");

endmodule

>>> tb/sv/matrix_keypad_scanner_debounced_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad scanner checker
// Watches the tick and result channels and the register port, runs its own
// model of the scanner on every accepted tick and compares each result
// transaction, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module matrix_keypad_scanner_debounced_checker (
   input  logic                            clock,
   input  logic                            reset,
   mkp_req_if                              req_if,
   mkp_rsp_if                              rsp_if,
   input  logic                            csr_wr_en,
   input  logic [mkp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mkp_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int unsigned                     fail_count,
   output int unsigned                     tick_count,
   output int unsigned                     key_count,
   output int unsigned                     bounce_count,
   output int unsigned                     pending_results,
   output logic [3:0]                      next_row_drive
);

   localparam logic [7:0] KEY_LEGEND [4][4] = '{
      '{"1", "2", "3", "A"},
      '{"4", "5", "6", "B"},
      '{"7", "8", "9", "C"},
      '{"*", "0", "#", "D"}
   };

   logic [7:0]  settle_ticks;
   logic [15:0] gap_ticks;
   logic [15:0] debounce_ticks;

   logic [1:0]  phase;
   logic [1:0]  purpose;
   logic [1:0]  scan_row;
   logic [15:0] wait_timer;
   logic [1:0]  held_row;
   logic [1:0]  held_col;

   mkp_pkg::rsp_type scan_result;
   mkp_pkg::rsp_type predicted_scans [$];
   int unsigned      results_seen;

   assign next_row_drive = (phase == mkp_pkg::PH_SCAN) ? ~(4'b0001 << scan_row) : 4'hF;

   task automatic report_failure(input string msg);
      $display("ERROR: %s", msg);
      fail_count++;
   endtask

   task automatic restart_scan();
      phase = mkp_pkg::PH_SCAN;
      scan_row = 2'd0;
      wait_timer = 16'd0;
   endtask

   task automatic close_wait(input logic [1:0] kind);
      if (kind == mkp_pkg::PH_DEBOUNCE && purpose == mkp_pkg::PUR_RELEASE) begin
         scan_result.key_ready = 1'b1;
         scan_result.key_char = KEY_LEGEND[held_row][held_col];
         purpose = mkp_pkg::PUR_PRESS;
      end
      restart_scan();
   endtask

   task automatic open_wait(input logic [1:0] kind, input logic [15:0] span);
      if (span == 16'd0) begin
         close_wait(kind);
      end else begin
         phase = kind;
         wait_timer = 16'd0;
      end
   endtask

   task automatic finish_scan(input logic hit, input logic [1:0] row, input logic [1:0] col);
      case (purpose)
         mkp_pkg::PUR_VERIFY: begin
            if (hit && row == held_row && col == held_col) begin
               purpose = mkp_pkg::PUR_RELEASE;
            end else begin
               scan_result.bounce_seen = 1'b1;
               purpose = mkp_pkg::PUR_PRESS;
            end
            restart_scan();
         end
         mkp_pkg::PUR_RELEASE: begin
            if (hit) begin
               open_wait(mkp_pkg::PH_GAP, gap_ticks);
            end else begin
               open_wait(mkp_pkg::PH_DEBOUNCE, debounce_ticks);
            end
         end
         default: begin
            purpose = mkp_pkg::PUR_PRESS;
            if (hit) begin
               held_row = row;
               held_col = col;
               purpose = mkp_pkg::PUR_VERIFY;
               open_wait(mkp_pkg::PH_DEBOUNCE, debounce_ticks);
            end else begin
               open_wait(mkp_pkg::PH_GAP, gap_ticks);
            end
         end
      endcase
   endtask

   task automatic step_scanner(input logic [3:0] levels);
      logic       hit;
      logic [1:0] hit_col;
      int         c;
      scan_result = '{row_drive: 4'hF, key_ready: 1'b0, key_char: 8'h00, bounce_seen: 1'b0};
      if (wait_timer != mkp_pkg::TIMER_MAX) begin
         wait_timer = wait_timer + 16'd1;
      end
      case (phase)
         mkp_pkg::PH_GAP: begin
            if (wait_timer >= gap_ticks) close_wait(mkp_pkg::PH_GAP);
         end
         mkp_pkg::PH_DEBOUNCE: begin
            if (wait_timer >= debounce_ticks) close_wait(mkp_pkg::PH_DEBOUNCE);
         end
         default: begin
            phase = mkp_pkg::PH_SCAN;
            scan_result.row_drive = ~(4'b0001 << scan_row);
            if (wait_timer >= {8'h00, settle_ticks}) begin
               hit = 1'b0;
               hit_col = 2'd0;
               for (c = mkp_pkg::FIELD_COLS - 1; c >= 0; c--) begin
                  if (!levels[c]) begin
                     hit = 1'b1;
                     hit_col = 2'(c);
                  end
               end
               if (hit) begin
                  finish_scan(1'b1, scan_row, hit_col);
               end else if (scan_row != 2'(mkp_pkg::FIELD_ROWS - 1)) begin
                  scan_row = scan_row + 2'd1;
                  wait_timer = 16'd0;
               end else begin
                  finish_scan(1'b0, 2'd0, 2'd0);
               end
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      mkp_pkg::rsp_type expected;
      if (reset) begin
         settle_ticks = 8'd1;
         gap_ticks = 16'd20;
         debounce_ticks = 16'd50;
         purpose = mkp_pkg::PUR_PRESS;
         held_row = 2'd0;
         held_col = 2'd0;
         restart_scan();
         predicted_scans.delete();
         fail_count = 0;
         tick_count = 0;
         key_count = 0;
         bounce_count = 0;
         results_seen = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               mkp_pkg::CSR_SETTLE:   settle_ticks = csr_wdata[7:0];
               mkp_pkg::CSR_SCAN_GAP: gap_ticks = csr_wdata;
               mkp_pkg::CSR_DEBOUNCE: debounce_ticks = csr_wdata;
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready) begin
            step_scanner(req_if.column_levels);
            predicted_scans.push_back(scan_result);
            tick_count++;
            if (scan_result.key_ready) key_count++;
            if (scan_result.bounce_seen) bounce_count++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (predicted_scans.size() == 0) begin
               report_failure($sformatf("result %0d arrived with no tick awaiting it",
                                        results_seen));
            end else begin
               expected = predicted_scans.pop_front();
               if (rsp_if.row_drive !== expected.row_drive)
                  report_failure($sformatf("result %0d: row_drive %b, expected %b",
                                           results_seen, rsp_if.row_drive, expected.row_drive));
               if (rsp_if.key_ready !== expected.key_ready)
                  report_failure($sformatf("result %0d: key_ready %b, expected %b",
                                           results_seen, rsp_if.key_ready, expected.key_ready));
               if (rsp_if.key_char !== expected.key_char)
                  report_failure($sformatf("result %0d: key_char %h, expected %h",
                                           results_seen, rsp_if.key_char, expected.key_char));
               if (rsp_if.bounce_seen !== expected.bounce_seen)
                  report_failure($sformatf("result %0d: bounce_seen %b, expected %b",
                                           results_seen, rsp_if.bounce_seen,
                                           expected.bounce_seen));
            end
            results_seen++;
         end
      end
      pending_results = predicted_scans.size();
   end

endmodule

>>> tb/sv/matrix_keypad_scanner_debounced_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad scanner testbench
// Emulates a keypad wired to the scanner's rows: keystrokes, chatter, chords
// and line noise are played one tick per transaction under several timing
// settings and idling patterns, while the checker predicts every result.
// ----------------------------------------------------------------------------
module matrix_keypad_scanner_debounced_tb;

   localparam int unsigned STALL_LIMIT = 2000;

   localparam int unsigned STROKE_CLEAN  = 0;
   localparam int unsigned STROKE_CHORD  = 1;
   localparam int unsigned STROKE_BOUNCE = 2;
   localparam int unsigned STROKE_NOISE  = 3;

   localparam logic [3:0] DIRECTED_LEVELS [22] = '{
      4'h0, 4'h0, 4'hF, 4'hF, 4'hF, 4'hF,
      4'hF, 4'h7, 4'hF, 4'hB,
      4'hE, 4'hF, 4'hF, 4'hF, 4'hF,
      4'hD, 4'hD, 4'hD, 4'hF, 4'hF, 4'hF, 4'hF
   };

   logic                            clock;
   logic                            reset;
   logic                            csr_wr_en;
   logic [mkp_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [mkp_pkg::CSR_DATA_W-1:0]  csr_wdata;

   int unsigned fail_count;
   int unsigned tick_count;
   int unsigned key_count;
   int unsigned bounce_count;
   int unsigned pending_results;
   logic [3:0]  next_row_drive;

   logic [15:0] keys_down;
   int unsigned send_idle_pct;
   int unsigned stall_pct;
   int unsigned cfg_settle;
   int unsigned cfg_gap;
   int unsigned cfg_debounce;
   int unsigned ticks_sent;
   int unsigned settings_run;
   int unsigned quiet_cycles = 0;

   mkp_req_if req_ch ();
   mkp_rsp_if rsp_ch ();

   matrix_keypad_scanner_debounced dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   matrix_keypad_scanner_debounced_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_if          (req_ch),
      .rsp_if          (rsp_ch),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .tick_count      (tick_count),
      .key_count       (key_count),
      .bounce_count    (bounce_count),
      .pending_results (pending_results),
      .next_row_drive  (next_row_drive)
   );

   always #1 clock = ~clock;

   always @(negedge clock) begin
      rsp_ch.ready <= !reset && ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("Timed out after %0d cycles without a transaction.", STALL_LIMIT);
         $display("matrix_keypad_scanner_debounced regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // The levels the keypad shows for the row that the scanner drives on the next tick.
   function automatic logic [3:0] keypad_levels();
      logic [3:0] levels;
      int         r;
      levels = 4'($urandom);
      for (r = 0; r < 4; r++) begin
         if (!next_row_drive[r]) levels = ~keys_down[r*4 +: 4];
      end
      return levels;
   endfunction

   task automatic send_tick(input logic [3:0] levels);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.column_levels <= levels;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      ticks_sent++;
   endtask

   task automatic write_csr(input logic [mkp_pkg::CSR_INDEX_W-1:0] index,
                            input logic [15:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   task automatic configure(input int unsigned settle, input int unsigned gap,
                            input int unsigned debounce);
      req_ch.valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      write_csr(mkp_pkg::CSR_SETTLE, 16'(settle));
      write_csr(mkp_pkg::CSR_SCAN_GAP, 16'(gap));
      write_csr(mkp_pkg::CSR_DEBOUNCE, 16'(debounce));
      csr_wr_en <= 1'b0;
      cfg_settle = settle;
      cfg_gap = gap;
      cfg_debounce = debounce;
      settings_run++;
   endtask

   task automatic play_keystroke(input int unsigned kind);
      int unsigned scan_span;
      int unsigned hold;
      int unsigned rest;
      int unsigned key;
      scan_span = 4 * ((cfg_settle == 0) ? 1 : cfg_settle);
      key = $urandom_range(15);
      hold = 2 * scan_span + cfg_gap + cfg_debounce + 2 + $urandom_range(scan_span);
      rest = scan_span + cfg_gap + cfg_debounce + 2 + $urandom_range(4);
      case (kind)
         STROKE_CLEAN, STROKE_CHORD: begin
            if ($urandom_range(2) == 0) begin
               repeat ($urandom_range(1, 6)) begin
                  keys_down = $urandom_range(1) ? (16'd1 << key) : 16'd0;
                  send_tick(keypad_levels());
               end
            end
            keys_down = 16'd1 << key;
            if (kind == STROKE_CHORD) keys_down[4'($urandom_range(15))] = 1'b1;
            repeat (hold) send_tick(keypad_levels());
         end
         STROKE_BOUNCE: begin
            keys_down = 16'd1 << key;
            repeat ($urandom_range(1, scan_span + cfg_debounce + 1)) send_tick(keypad_levels());
            if ($urandom_range(1) == 1) begin
               keys_down = 16'd1 << $urandom_range(15);
               repeat ($urandom_range(1, 2 * scan_span)) send_tick(keypad_levels());
            end
         end
         default: begin
            repeat ($urandom_range(1, 8)) send_tick(4'($urandom));
         end
      endcase
      keys_down = 16'd0;
      repeat (rest) send_tick(keypad_levels());
   endtask

   task automatic type_keys(input int unsigned budget);
      int unsigned start;
      int unsigned pick;
      start = ticks_sent;
      while (ticks_sent - start < budget) begin
         pick = $urandom_range(99);
         if (pick < 60) play_keystroke(STROKE_CLEAN);
         else if (pick < 72) play_keystroke(STROKE_CHORD);
         else if (pick < 88) play_keystroke(STROKE_BOUNCE);
         else play_keystroke(STROKE_NOISE);
      end
   endtask

   task automatic set_idling(input int unsigned send_pct, input int unsigned stall);
      send_idle_pct = send_pct;
      stall_pct = stall;
   endtask

   initial begin
      int i;
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.column_levels = 4'hF;
      rsp_ch.ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = mkp_pkg::CSR_SETTLE;
      csr_wdata = '0;
      keys_down = 16'd0;
      set_idling(0, 0);
      cfg_settle = 1;
      cfg_gap = 20;
      cfg_debounce = 50;
      ticks_sent = 0;
      settings_run = 1;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      type_keys(40);

      configure(1, 0, 0);
      repeat (8) send_tick(4'hF);
      while (next_row_drive != 4'b1110) send_tick(4'hF);
      for (i = 0; i < 22; i++) send_tick(DIRECTED_LEVELS[i]);

      configure(0, 0, 0);
      type_keys(40);
      configure(1, 1, 2);
      set_idling(55, 0);
      type_keys(40);
      configure(2, 3, 4);
      set_idling(0, 55);
      type_keys(40);
      configure(3, 0, 5);
      set_idling(24, 24);
      type_keys(40);
      configure($urandom_range(0, 4), $urandom_range(0, 6), $urandom_range(0, 6));
      set_idling(0, 0);
      type_keys(40);
      configure(255, 65535, 65535);
      repeat (24) send_tick(4'($urandom));

      req_ch.valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      $display("Checked %0d scan ticks under %0d timing settings, zero waits to full scale.",
               tick_count, settings_run);
      $display("The model saw %0d keys reported and %0d bounces flagged; %0d mismatches.",
               key_count, bounce_count, fail_count);
      if (fail_count == 0 && pending_results == 0) begin
         $display("matrix_keypad_scanner_debounced regression: pass");
      end else begin
         $display("matrix_keypad_scanner_debounced regression: fail");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/mkp_pkg.sv
rtl/mkp_chan_if.sv
rtl/mkp_core.sv
rtl/matrix_keypad_scanner_debounced.sv
tb/sv/matrix_keypad_scanner_debounced_checker.sv
tb/sv/matrix_keypad_scanner_debounced_tb.sv
